// ===== src/osps_pkg.sv =====
package osps_pkg;

    localparam int MAX_LIMIT   = 65536;
    localparam int LIMIT_RESET = 65536;
    localparam int NUM_W       = 17;                       // field width of number and limit
    localparam int LIM_W       = $clog2(MAX_LIMIT + 1);    // saturated limit
    localparam int ADDR_W      = $clog2(MAX_LIMIT / 2);    // bit k stands for 2k+3
    localparam int DEPTH       = 2 ** ADDR_W;
    localparam int J_W         = LIM_W + 1;                // multiples and squares overshoot
    localparam int I_W         = (LIM_W + 1) / 2 + 1;      // outer index, up to ~sqrt(limit)+2

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DONE      = 2'd1,
        ST_NOT_BUILT = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// ===== src/osps_bitram.sv =====
module osps_bitram (
    input  logic               i_clk,
    input  osps_pkg::t_mem_req i_req,
    output logic               o_rdata
);

    logic r_mem [osps_pkg::DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/osps_builder.sv =====
module osps_builder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [osps_pkg::LIM_W-1:0] i_lim,
    input  logic                       i_rdata,
    output osps_pkg::t_mem_req         o_mem,
    output logic                       o_done
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_FILL,
        B_OUTER,
        B_TEST,
        B_CROSS,
        B_NEXT
    } t_bstate;

    t_bstate                       r_state;
    logic                          r_done;
    logic [osps_pkg::LIM_W-1:0]    r_lim;
    logic [osps_pkg::ADDR_W-1:0]   r_kmax;
    logic [osps_pkg::J_W-1:0]      r_j;
    logic [osps_pkg::J_W-1:0]      r_sq;
    logic [osps_pkg::I_W-1:0]      r_i;
    logic [osps_pkg::I_W:0]        r_step;

    logic [osps_pkg::J_W-1:0]      w_a;
    logic [osps_pkg::J_W-1:0]      w_b;
    logic [osps_pkg::J_W-1:0]      w_sum;
    logic [osps_pkg::J_W-1:0]      w_lim;
    logic [osps_pkg::I_W+1:0]      w_inc;
    logic [osps_pkg::I_W-1:0]      w_ik;
    logic [osps_pkg::J_W-1:0]      w_jk;

    assign w_lim = osps_pkg::J_W'(r_lim);
    // (i+2)^2 = i^2 + 4(i+1)
    assign w_inc = {r_i + osps_pkg::I_W'(1), 2'b00};
    assign w_ik  = (r_i - osps_pkg::I_W'(3)) >> 1;
    assign w_jk  = (r_j - osps_pkg::J_W'(3)) >> 1;

    // shared adder: fill counter, stride step, square update
    always_comb begin
        case (r_state)
            B_FILL: begin
                w_a = r_j;
                w_b = osps_pkg::J_W'(1);
            end
            B_NEXT: begin
                w_a = r_sq;
                w_b = osps_pkg::J_W'(w_inc);
            end
            default: begin
                w_a = r_j;
                w_b = osps_pkg::J_W'(r_step);
            end
        endcase
        w_sum = w_a + w_b;
    end

    always_comb begin
        o_mem = '0;
        case (r_state)
            B_FILL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_j[osps_pkg::ADDR_W-1:0];
                o_mem.wdata = 1'b1;
            end
            B_OUTER: begin
                o_mem.re    = (r_sq <= w_lim);
                o_mem.raddr = osps_pkg::ADDR_W'(w_ik);
            end
            B_CROSS: begin
                o_mem.we    = (r_j <= w_lim);
                o_mem.waddr = osps_pkg::ADDR_W'(w_jk);
                o_mem.wdata = 1'b0;
            end
            default: begin
                o_mem = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == B_OUTER) && !(r_sq <= w_lim);
            case (r_state)
                B_IDLE: begin
                    if (i_start) begin
                        r_lim  <= i_lim;
                        r_kmax <= osps_pkg::ADDR_W'((i_lim - osps_pkg::LIM_W'(3)) >> 1);
                        r_j    <= '0;
                        r_i    <= osps_pkg::I_W'(3);
                        r_sq   <= osps_pkg::J_W'(9);
                        r_step <= (osps_pkg::I_W + 1)'(6);
                        r_state <= (i_lim >= osps_pkg::LIM_W'(3)) ? B_FILL : B_OUTER;
                    end
                end
                B_FILL: begin
                    if (r_j[osps_pkg::ADDR_W-1:0] == r_kmax) begin
                        r_state <= B_OUTER;
                    end else begin
                        r_j <= w_sum;
                    end
                end
                B_OUTER: begin
                    if (r_sq <= w_lim) begin
                        r_state <= B_TEST;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_TEST: begin
                    if (i_rdata) begin
                        r_j     <= r_sq;
                        r_state <= B_CROSS;
                    end else begin
                        r_state <= B_NEXT;
                    end
                end
                B_CROSS: begin
                    if (r_j <= w_lim) begin
                        r_j <= w_sum;
                    end else begin
                        r_state <= B_NEXT;
                    end
                end
                B_NEXT: begin
                    r_sq    <= w_sum;
                    r_i     <= r_i + osps_pkg::I_W'(2);
                    r_step  <= r_step + (osps_pkg::I_W + 1)'(4);
                    r_state <= B_OUTER;
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;

endmodule

// ===== src/odd_only_prime_sieve.sv =====
// Query: S_QRY loads the answer into the output register; requests stall until S_IDLE.
// Build: fill marks every odd entry up to L, then for each odd i with i*i <= L the bit of i
//   is read and tested, and if still marked its multiples from i*i are crossed out; then
//   done is posted (L = saturated limit), with at most one bit map access per state.
// Reset (synchronous, active low) clears control, is_built and built_limit; the bit map is
//   not cleared and needs no clearing pass. The limit register resets to MAX_LIMIT.
module odd_only_prime_sieve (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_sieve_limit,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [16:0] i_number,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_prime,
    output logic [1:0]  o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_DONE,
        S_QRY
    } t_state;

    t_state                         r_state;
    logic [osps_pkg::NUM_W-1:0]     r_limit;
    logic                           r_built;
    logic [osps_pkg::LIM_W-1:0]     r_built_limit;
    logic [osps_pkg::NUM_W-1:0]     r_num;
    logic                           r_out_valid;
    logic                           r_is_prime;
    osps_pkg::t_status              r_status;

    logic                           w_in_accept;
    logic                           w_out_free;
    logic                           w_post;
    logic                           w_start;
    logic [31:0]                    w_lim32;
    logic [osps_pkg::LIM_W-1:0]     w_lim;
    logic [osps_pkg::NUM_W-1:0]     w_qk;
    osps_pkg::t_mem_req             w_bld_mem;
    osps_pkg::t_mem_req             w_mem;
    logic                           w_rdata;
    logic                           w_bld_done;
    osps_pkg::t_status              w_q_status;
    logic                           w_q_prime;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    // a result is loaded into the output register this cycle
    assign w_post      = (r_state inside {S_DONE, S_QRY}) && w_out_free;
    assign w_start     = w_in_accept && (i_cmd == osps_pkg::CMD_BUILD);

    // configuration register, to be written by the user only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= osps_pkg::NUM_W'(osps_pkg::LIMIT_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_sieve_limit;
        end
    end

    // limit saturated into 2..MAX_LIMIT at build time
    always_comb begin
        w_lim32 = 32'(r_limit);
        if (w_lim32 < 32'd2) begin
            w_lim32 = 32'd2;
        end else if (w_lim32 > 32'(osps_pkg::MAX_LIMIT)) begin
            w_lim32 = 32'(osps_pkg::MAX_LIMIT);
        end
        w_lim = osps_pkg::LIM_W'(w_lim32);
    end

    // query address: bit k for odd 2k+3; garbage for other numbers is ignored
    assign w_qk = (i_number - osps_pkg::NUM_W'(3)) >> 1;

    always_comb begin
        if (r_state == S_BUILD) begin
            w_mem = w_bld_mem;
        end else begin
            w_mem       = '0;
            w_mem.re    = w_in_accept && (i_cmd == osps_pkg::CMD_QUERY);
            w_mem.raddr = osps_pkg::ADDR_W'(w_qk);
        end
    end

    osps_builder u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_lim   (w_lim),
        .i_rdata (w_rdata),
        .o_mem   (w_bld_mem),
        .o_done  (w_bld_done)
    );

    osps_bitram u_bitram (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // query answer; bit map data is held in the read register until used
    always_comb begin
        w_q_prime = 1'b0;
        if (!r_built) begin
            w_q_status = osps_pkg::ST_NOT_BUILT;
        end else if (32'(r_num) > 32'(r_built_limit)) begin
            w_q_status = osps_pkg::ST_RANGE;
        end else begin
            w_q_status = osps_pkg::ST_OK;
            if (r_num == osps_pkg::NUM_W'(2)) begin
                w_q_prime = 1'b1;
            end else if (r_num[0] && (r_num >= osps_pkg::NUM_W'(3))) begin
                w_q_prime = w_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_built       <= 1'b0;
            r_built_limit <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_post) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        if (i_cmd == osps_pkg::CMD_BUILD) begin
                            r_built       <= 1'b1;
                            r_built_limit <= w_lim;
                            r_state       <= S_BUILD;
                        end else begin
                            r_num   <= i_number;
                            r_state <= S_QRY;
                        end
                    end
                end
                S_BUILD: begin
                    if (w_bld_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_is_prime  <= 1'b0;
                        r_status    <= osps_pkg::ST_DONE;
                        r_state     <= S_IDLE;
                    end
                end
                S_QRY: begin
                    if (w_out_free) begin
                        r_is_prime  <= w_q_prime;
                        r_status    <= w_q_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_is_prime;
    assign o_status    = r_status;

    // only the build sequencer writes the bit map
    a_write_only_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.we |-> (r_state == S_BUILD))
        else $error("bit map written outside a build");

    // an accepted build hands control to the sequencer
    a_build_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == S_BUILD))
        else $error("build request did not start the sequencer");

    // is_prime is only set on a good query
    a_prime_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != osps_pkg::ST_OK)) |-> !r_is_prime)
        else $error("is_prime set on a non-ok result");

    // a good query answer needs a built map
    a_ok_needs_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == osps_pkg::ST_OK)) |-> r_built)
        else $error("ok status before any build");

endmodule

// ===== tb/sieve_checker.sv =====
`timescale 1ns / 1ps
module sieve_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [16:0] i_sieve_limit,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_cmd,
    input  logic [16:0] i_number,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_is_prime,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic              is_prime;
        osps_pkg::t_status status;
    } t_answer;

    bit          odd_is_prime [osps_pkg::MAX_LIMIT/2 + 1];   // entry k stands for 2k+3
    logic [16:0] limit_reg;
    logic [16:0] built_limit;
    logic        built;
    t_answer     pending_answers [$];
    int          errors = 0;

    function automatic void sieve_up_to(int lim);
        for (int n = 3; n <= lim; n += 2)
            odd_is_prime[(n - 3) / 2] = 1'b1;
        for (int p = 3; p * p <= lim; p += 2) begin
            if (odd_is_prime[(p - 3) / 2]) begin
                for (int m = p * p; m <= lim; m += 2 * p)
                    odd_is_prime[(m - 3) / 2] = 1'b0;
            end
        end
    endfunction

    function automatic t_answer predict_answer(logic cmd, logic [16:0] num);
        t_answer a;
        int      lim;
        a.is_prime = 1'b0;
        a.status   = osps_pkg::ST_OK;
        if (cmd == osps_pkg::CMD_BUILD) begin
            // limit saturates into 2..MAX_LIMIT at build time
            lim = int'(limit_reg);
            if (lim < 2) lim = 2;
            if (lim > osps_pkg::MAX_LIMIT) lim = osps_pkg::MAX_LIMIT;
            sieve_up_to(lim);
            built_limit = lim[16:0];
            built       = 1'b1;
            a.status    = osps_pkg::ST_DONE;
        end else if (!built) begin
            a.status = osps_pkg::ST_NOT_BUILT;
        end else if (num > built_limit) begin
            a.status = osps_pkg::ST_RANGE;
        end else if (num == 17'd2) begin
            a.is_prime = 1'b1;
        end else if (num >= 17'd3 && num[0]) begin
            a.is_prime = odd_is_prime[(int'(num) - 3) / 2];
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            limit_reg   = 17'(osps_pkg::LIMIT_RESET);
            built_limit = '0;
            built       = 1'b0;
            pending_answers.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                limit_reg = i_sieve_limit;
            // results first: a request taken on this edge cannot answer on it
            if (i_out_valid && !i_out_stall) begin
                if (pending_answers.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with no request outstanding: %s%0d status=%0d",
                                 $time, "is_prime=", i_is_prime, i_status);
                end else begin
                    want = pending_answers.pop_front();
                    if (want.is_prime !== i_is_prime || want.status !== i_status) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: mismatch: expected is_prime=%0d status=%0d, ",
                                      "got is_prime=%0d status=%0d"},
                                     $time, want.is_prime, want.status,
                                     i_is_prime, i_status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_answers = {pending_answers, predict_answer(i_cmd, i_number)};
        end
        o_errors  <= errors;
        o_pending <= pending_answers.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int N_ITEMS   = 1450;   // requests to send in all
    localparam int QUIET_LEN = 150;    // closing stretch without idling on either side
    localparam int HOLD_AT   = 400;    // request count that triggers the long result hold-off
    localparam int HOLD_LEN  = 300;    // cycles of that hold-off

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_sieve_limit = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_cmd         = osps_pkg::CMD_QUERY;
    logic [16:0] i_number      = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic        o_is_prime;
    logic [1:0]  o_status;

    int          err_count;
    int          pending;
    int          items_sent = 0;
    bit          gaps_on    = 1'b1;
    bit          held       = 1'b0;
    // stimulus-side view of the limits, only used to aim query numbers
    logic [16:0] cfg_lim    = 17'(osps_pkg::LIMIT_RESET);
    logic [16:0] built_lim  = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    odd_only_prime_sieve uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_sieve_limit (i_sieve_limit),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_number      (i_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_prime    (o_is_prime),
        .o_status      (o_status)
    );

    // checker watches all three channels, predicts and compares
    sieve_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_sieve_limit (i_sieve_limit),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_number      (i_number),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_is_prime    (o_is_prime),
        .i_status      (o_status),
        .o_errors      (err_count),
        .o_pending     (pending)
    );

    function automatic logic [16:0] clamp_limit(logic [16:0] v);
        if (v < 17'd2) return 17'd2;
        if (v > 17'(osps_pkg::MAX_LIMIT)) return 17'(osps_pkg::MAX_LIMIT);
        return v;
    endfunction

    // Mostly small limits: a build walks the map up to the limit, so its work grows
    // with the limit. The extremes are covered in the directed part.
    function automatic logic [16:0] pick_limit();
        case ($urandom_range(0, 19))
            0, 1:    return 17'($urandom_range(0, 20));
            2, 3, 4: return 17'($urandom_range(3001, 20000));
            default: return 17'($urandom_range(21, 3000));
        endcase
    endfunction

    // Query numbers: mostly inside the built range, some right at its edge,
    // some small, some anywhere in the 17-bit field.
    function automatic logic [16:0] pick_number();
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 131071);
            1: v = int'(built_lim) + $urandom_range(0, 8) - 4;
            2: v = $urandom_range(0, 64);
            default: v = $urandom_range(0, int'(built_lim));
        endcase
        if (v < 0) v = 0;
        return v[16:0];
    endfunction

    // One request; returns on the edge that accepts it.
    // Valid stays up and the payload holds while the block stalls.
    task automatic send_req(input logic cmd, input logic [16:0] num);
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_number   <= num;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (cmd == osps_pkg::CMD_BUILD) built_lim = cfg_lim;
    endtask

    // Random sender gap, none in the closing stretch.
    task automatic sender_gap();
        if (gaps_on && items_sent < N_ITEMS - QUIET_LEN && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Wait until every request has answered. The first edge lets the
    // checker's count catch up with a request taken on the current edge.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Limit writes happen only with the block idle.
    task automatic write_limit(input logic [16:0] v);
        drain();
        i_cfg_valid   <= 1'b1;
        i_sieve_limit <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_lim = clamp_limit(v);
    endtask

    // result side: random stall bursts, one long hold-off, quiet at the end
    initial begin
        @(posedge i_clk);
        forever begin
            if (!held && items_sent >= HOLD_AT) begin
                // long hold-off while requests keep coming: block must back up
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if (items_sent >= N_ITEMS - QUIET_LEN) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // nothing built yet: every query reports not built, even 0, 1 and 2
        send_req(osps_pkg::CMD_QUERY, 17'd0);
        send_req(osps_pkg::CMD_QUERY, 17'd1);
        send_req(osps_pkg::CMD_QUERY, 17'd2);
        send_req(osps_pkg::CMD_QUERY, 17'd3);
        send_req(osps_pkg::CMD_QUERY, 17'h1FFFF);

        // build with the limit register untouched since reset (full range)
        send_req(osps_pkg::CMD_BUILD, 17'h1FFFF);
        send_req(osps_pkg::CMD_QUERY, 17'd0);
        send_req(osps_pkg::CMD_QUERY, 17'd1);
        send_req(osps_pkg::CMD_QUERY, 17'd2);
        send_req(osps_pkg::CMD_QUERY, 17'd9);          // odd square, must be crossed out
        send_req(osps_pkg::CMD_QUERY, 17'd25);
        send_req(osps_pkg::CMD_QUERY, 17'd65521);      // largest prime in range
        send_req(osps_pkg::CMD_QUERY, 17'd65535);
        send_req(osps_pkg::CMD_QUERY, 17'd65536);      // top of range, even
        send_req(osps_pkg::CMD_QUERY, 17'd65537);      // just above the built limit
        send_req(osps_pkg::CMD_QUERY, 17'h1FFFF);
        send_req(osps_pkg::CMD_QUERY, 17'd3);

        // limit below the floor saturates to 2: only 0..2 in range
        write_limit(17'd0);
        send_req(osps_pkg::CMD_BUILD, 17'd0);
        send_req(osps_pkg::CMD_QUERY, 17'd2);
        send_req(osps_pkg::CMD_QUERY, 17'd3);
        send_req(osps_pkg::CMD_QUERY, 17'd1);

        // limit exactly at an odd square
        write_limit(17'd9);
        send_req(osps_pkg::CMD_BUILD, 17'd5);
        send_req(osps_pkg::CMD_QUERY, 17'd9);
        send_req(osps_pkg::CMD_QUERY, 17'd7);

        // limit above the ceiling saturates to MAX_LIMIT
        write_limit(17'h1FFFF);
        send_req(osps_pkg::CMD_BUILD, 17'd0);
        send_req(osps_pkg::CMD_QUERY, 17'd65521);

        // --- random phases: new limit, build, then a batch of queries ---
        while (items_sent < N_ITEMS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                write_limit(pick_limit());
            // sometimes query against the old map after a limit change
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    sender_gap();
                    send_req(osps_pkg::CMD_QUERY, pick_number());
                end
            end
            sender_gap();
            send_req(osps_pkg::CMD_BUILD, 17'($urandom_range(0, 131071)));
            n = $urandom_range(20, 70);
            for (int q = 0; q < n && items_sent < N_ITEMS; q++) begin
                sender_gap();
                if ($urandom_range(0, 39) == 0)
                    send_req(osps_pkg::CMD_BUILD, 17'($urandom_range(0, 131071)));
                else
                    send_req(osps_pkg::CMD_QUERY, pick_number());
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS odd_only_prime_sieve");
        else
            $display("FAIL odd_only_prime_sieve");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #100_000_000;
        $display("FAIL odd_only_prime_sieve");
        $finish;
    end

endmodule
